// ----- sv/lav_pkg.sv -----
// lav_pkg: shared widths, types and constants for the look-at view matrix pipeline.
// Used by every module of the block; depends on nothing.
package lav_pkg;

  localparam int FRAC_BITS = 16;

  localparam int WW   = 32;              // input coordinates and matrix entries
  localparam int UW   = FRAC_BITS + 2;   // unit vector component, |c| <= 1.0
  localparam int VW   = UW + WW;         // vector component fed to normalization
  localparam int NB   = 30;              // normalized magnitude, max in [2^29, 2^30)
  localparam int SQW  = 2 * NB + 2;      // sum of three squares
  localparam int RTW  = NB + 1;          // square root / divisor
  localparam int QW   = FRAC_BITS + 1;   // quotient of one component
  localparam int NW   = NB + FRAC_BITS + 1;

  localparam logic [1:0] FIRST_COL = 2'd0;
  localparam logic [1:0] LAST_COL  = 2'd3;

  typedef logic signed [WW-1:0] word_t;
  typedef logic signed [UW-1:0] ucomp_t;
  typedef logic signed [VW-1:0] vcomp_t;

  localparam word_t ONE_Q = WW'(1) << FRAC_BITS;

  // item context carried alongside the vector being normalized
  typedef struct packed {
    word_t  [2:0] eye;
    word_t  [2:0] up;
    ucomp_t [2:0] f;
    ucomp_t [2:0] s;
    logic         degen;
  } side_t;

  // everything needed to emit the four columns of one item
  typedef struct packed {
    ucomp_t [2:0] s;
    ucomp_t [2:0] u;
    ucomp_t [2:0] f;
    word_t  [2:0] t;
    logic         degen;
  } colset_t;

endpackage

// ----- sv/lav_unit.sv -----
// lav_unit: pipelined unit-vector stage (normalize, sum of squares, root, divide).
// Depends on lav_pkg.
module lav_unit
  import lav_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_vld,
  input  vcomp_t [2:0] in_vec,
  input  side_t        in_side,
  output logic         out_vld,
  output ucomp_t [2:0] out_vec,
  output logic         out_zero,
  output side_t        out_side
);

  localparam int PW   = $clog2(VW);
  localparam int XW   = VW + NB - 1;
  localparam int SQ_N = RTW;
  localparam int PREP = 6 + SQ_N;
  localparam int DV0  = PREP + 1;
  localparam int NST  = DV0 + QW + 1;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
    side_t      side;
  } uctl_t;

  typedef logic [NB-1:0] nmag_t;

  logic  v_r [NST];
  uctl_t c_r [NST];
  uctl_t c_nxt;

  logic [2:0][VW-1:0] mag_r, mag_nxt, mg1_r, mg2_r;
  logic [VW-1:0]      mx_r, mx_nxt;
  logic [PW-1:0]      p_r, p_nxt;
  nmag_t [2:0]        a4_r, a4_nxt, a5_r, a6_r;
  logic [2:0][2*NB-1:0] sq_r;
  logic [SQW-1:0]     n_r;

  logic [SQW-1:0]     rem_r  [SQ_N];
  logic [RTW-1:0]     root_r [SQ_N];
  nmag_t [2:0]        asq_r  [SQ_N];

  logic [2:0][RTW-1:0] pr_r, pr_nxt;
  logic [2:0][QW-1:0]  pl_r, pl_nxt;
  logic [RTW-1:0]      pd_r;

  logic [2:0][RTW-1:0] dr_r [QW];
  logic [2:0][QW-1:0]  dq_r [QW];
  logic [2:0][QW-1:0]  dl_r [QW];
  logic [RTW-1:0]      dd_r [QW];

  ucomp_t [2:0] uo_r, uo_nxt;

  // valid and context travel together through every stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_vld;
      for (int k = 1; k < NST; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r[0] <= c_nxt;
      for (int k = 1; k < NST; k++) c_r[k] <= c_r[k-1];
    end
  end

  // stage 1: magnitudes and signs
  always_comb begin
    c_nxt.side = in_side;
    c_nxt.zero = (in_vec[0] == '0) && (in_vec[1] == '0) && (in_vec[2] == '0);
    for (int i = 0; i < 3; i++) begin
      c_nxt.neg[i] = in_vec[i][VW-1];
      mag_nxt[i]   = in_vec[i][VW-1] ? -in_vec[i] : in_vec[i];
    end
  end

  // stage 2: largest magnitude
  always_comb begin
    mx_nxt = mag_r[0];
    if (mag_r[1] > mx_nxt) mx_nxt = mag_r[1];
    if (mag_r[2] > mx_nxt) mx_nxt = mag_r[2];
  end

  // stage 3: leading one of the largest magnitude
  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < VW; i++) begin
      if (mx_r[i]) p_nxt = PW'(i);
    end
  end

  // stage 4: scale so that the top bit lands on bit NB-1; right shifts truncate
  always_comb begin
    logic [XW-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      sh        = {mg2_r[i], {(NB-1){1'b0}}} >> p_r;
      a4_nxt[i] = sh[NB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
      mx_r  <= mx_nxt;
      mg1_r <= mag_r;
      p_r   <= p_nxt;
      mg2_r <= mg1_r;
      a4_r  <= a4_nxt;
      for (int i = 0; i < 3; i++) sq_r[i] <= a4_r[i] * a4_r[i];
      a5_r  <= a4_r;
      n_r   <= SQW'(sq_r[0]) + SQW'(sq_r[1]) + SQW'(sq_r[2]);
      a6_r  <= a5_r;
    end
  end

  // floor square root, one root bit per stage
  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    localparam int B = SQ_N - 1 - j;
    logic [SQW-1:0] rem_in, trial;
    logic [RTW-1:0] root_in;
    nmag_t [2:0]    a_in;

    if (j == 0) begin : g_first
      assign rem_in  = n_r;
      assign root_in = '0;
      assign a_in    = a6_r;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign a_in    = asq_r[j-1];
    end

    // (root + 2^B)^2 - root^2; the two terms have no bits in common
    assign trial = (SQW'(root_in) << (B + 1)) | (SQW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_r[j]  <= rem_in - trial;
          root_r[j] <= root_in | (RTW'(1) << B);
        end else begin
          rem_r[j]  <= rem_in;
          root_r[j] <= root_in;
        end
        asq_r[j] <= a_in;
      end
    end
  end

  // divide prep: numerator (a << FRAC_BITS) + len/2, split into head and low bits
  always_comb begin
    logic [NW-1:0] num;
    for (int i = 0; i < 3; i++) begin
      num       = (NW'(asq_r[SQ_N-1][i]) << FRAC_BITS) + NW'(root_r[SQ_N-1] >> 1);
      pr_nxt[i] = RTW'(num >> QW);
      pl_nxt[i] = num[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_r <= pr_nxt;
      pl_r <= pl_nxt;
      pd_r <= root_r[SQ_N-1];
    end
  end

  // restoring division, one quotient bit per stage, three lanes
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int QB = QW - 1 - j;
    logic [2:0][RTW-1:0] r_in, r_nxt;
    logic [2:0][QW-1:0]  q_in, q_nxt, l_in;
    logic [RTW-1:0]      d_in;

    if (j == 0) begin : g_first
      assign r_in = pr_r;
      assign q_in = '0;
      assign l_in = pl_r;
      assign d_in = pd_r;
    end else begin : g_next
      assign r_in = dr_r[j-1];
      assign q_in = dq_r[j-1];
      assign l_in = dl_r[j-1];
      assign d_in = dd_r[j-1];
    end

    always_comb begin
      logic [RTW:0] t;
      q_nxt = q_in;
      for (int c = 0; c < 3; c++) begin
        t = {r_in[c], l_in[c][QB]};
        if (t >= {1'b0, d_in}) begin
          r_nxt[c]     = RTW'(t - {1'b0, d_in});
          q_nxt[c][QB] = 1'b1;
        end else begin
          r_nxt[c]     = t[RTW-1:0];
          q_nxt[c][QB] = 1'b0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dr_r[j] <= r_nxt;
        dq_r[j] <= q_nxt;
        dl_r[j] <= l_in;
        dd_r[j] <= d_in;
      end
    end
  end

  // final: restore signs; a zero-length vector comes out as zeros
  always_comb begin
    ucomp_t qs;
    for (int c = 0; c < 3; c++) begin
      qs = UW'(dq_r[QW-1][c]);
      if (c_r[NST-2].zero) begin
        uo_nxt[c] = '0;
      end else begin
        uo_nxt[c] = c_r[NST-2].neg[c] ? -qs : qs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) uo_r <= uo_nxt;
  end

  assign out_vld  = v_r[NST-1];
  assign out_vec  = uo_r;
  assign out_zero = c_r[NST-1].zero;
  assign out_side = c_r[NST-1].side;

endmodule

// ----- sv/lav_cross.sv -----
// lav_cross: two-stage cross product a x b (products, then differences).
// Depends on lav_pkg.
module lav_cross
  import lav_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_vld,
  input  ucomp_t [2:0] in_a,
  input  word_t  [2:0] in_b,
  input  side_t        in_side,
  output logic         out_vld,
  output vcomp_t [2:0] out_vec,
  output side_t        out_side
);

  logic [1:0]   v_r;
  side_t        sd_r [2];
  vcomp_t [5:0] prd_r, prd_nxt;
  vcomp_t [2:0] vec_r, vec_nxt;

  always_comb begin
    prd_nxt[0] = $signed(in_a[1]) * $signed(in_b[2]);
    prd_nxt[1] = $signed(in_a[2]) * $signed(in_b[1]);
    prd_nxt[2] = $signed(in_a[2]) * $signed(in_b[0]);
    prd_nxt[3] = $signed(in_a[0]) * $signed(in_b[2]);
    prd_nxt[4] = $signed(in_a[0]) * $signed(in_b[1]);
    prd_nxt[5] = $signed(in_a[1]) * $signed(in_b[0]);
  end

  always_comb begin
    vec_nxt[0] = prd_r[0] - prd_r[1];
    vec_nxt[1] = prd_r[2] - prd_r[3];
    vec_nxt[2] = prd_r[4] - prd_r[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prd_r   <= prd_nxt;
      sd_r[0] <= in_side;
      vec_r   <= vec_nxt;
      sd_r[1] <= sd_r[0];
    end
  end

  assign out_vld  = v_r[1];
  assign out_vec  = vec_r;
  assign out_side = sd_r[1];

endmodule

// ----- sv/lav_dot.sv -----
// lav_dot: three-stage translation column (s.eye, u.eye, f.eye), rounded and saturated.
// Depends on lav_pkg.
module lav_dot
  import lav_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_vld,
  input  ucomp_t [2:0] in_s,
  input  ucomp_t [2:0] in_u,
  input  ucomp_t [2:0] in_f,
  input  word_t  [2:0] in_eye,
  input  logic         in_degen,
  output logic         out_vld,
  output colset_t      out_cols
);

  // s and u rows are negated, f row is not
  localparam logic [2:0] FLIP = 3'b011;
  localparam logic [VW-1:0] NEG_LIM = VW'(1) << (WW - 1);
  localparam logic [VW-1:0] POS_LIM = NEG_LIM - VW'(1);
  localparam logic [VW-1:0] HALF    = VW'(1) << (FRAC_BITS - 1);
  localparam word_t W_MIN = {1'b1, {(WW-1){1'b0}}};
  localparam word_t W_MAX = {1'b0, {(WW-1){1'b1}}};

  logic [2:0]    v_r;
  colset_t       car_r [2];
  colset_t       car_nxt;
  vcomp_t [8:0]  prd_r, prd_nxt;
  vcomp_t [2:0]  sum_r, sum_nxt;
  colset_t       col_r, col_nxt;

  always_comb begin
    car_nxt       = '0;
    car_nxt.s     = in_s;
    car_nxt.u     = in_u;
    car_nxt.f     = in_f;
    car_nxt.degen = in_degen;
    for (int i = 0; i < 3; i++) begin
      prd_nxt[i]     = $signed(in_s[i]) * $signed(in_eye[i]);
      prd_nxt[3 + i] = $signed(in_u[i]) * $signed(in_eye[i]);
      prd_nxt[6 + i] = $signed(in_f[i]) * $signed(in_eye[i]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_nxt[k] = prd_r[3*k] + prd_r[3*k + 1] + prd_r[3*k + 2];
    end
  end

  // round half away from zero on the magnitude, then clamp to 32 bits
  always_comb begin
    logic [VW-1:0] m, mr;
    logic          neg;
    col_nxt = car_r[1];
    for (int k = 0; k < 3; k++) begin
      m   = sum_r[k][VW-1] ? -sum_r[k] : sum_r[k];
      neg = sum_r[k][VW-1] ^ FLIP[k];
      mr  = (m + HALF) >> FRAC_BITS;
      if (neg) begin
        col_nxt.t[k] = (mr > NEG_LIM) ? W_MIN : WW'(-mr);
      end else begin
        col_nxt.t[k] = (mr > POS_LIM) ? W_MAX : WW'(mr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prd_r    <= prd_nxt;
      car_r[0] <= car_nxt;
      sum_r    <= sum_nxt;
      car_r[1] <= car_r[0];
      col_r    <= col_nxt;
    end
  end

  assign out_vld  = v_r[2];
  assign out_cols = col_r;

endmodule

// ----- sv/look_at_view_matrix.sv -----
// look_at_view_matrix: builds the look-at view matrix of each accepted item, entries in Q16.16
// at FRAC_BITS = 16, and emits it as four columns in order, column 0 first, one per output transfer.
// A single output register holds one item while it emits its four columns, and the pipeline
// stalls as a whole behind it. Reset (rst_n low, synchronous) clears all valids.
// Depends on lav_pkg, lav_unit, lav_cross, lav_dot.
module look_at_view_matrix
  import lav_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  word_t      in_eye_x,
  input  word_t      in_eye_y,
  input  word_t      in_eye_z,
  input  word_t      in_target_x,
  input  word_t      in_target_y,
  input  word_t      in_target_z,
  input  word_t      in_up_x,
  input  word_t      in_up_y,
  input  word_t      in_up_z,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_column_index,
  output word_t      out_row0_value,
  output word_t      out_row1_value,
  output word_t      out_row2_value,
  output word_t      out_row3_value,
  output logic       out_last_column,
  output logic       out_degenerate
);

  logic en, take;

  logic         v0_r;
  vcomp_t [2:0] view_r, view_nxt;
  side_t        sd0_r, sd0_nxt;

  logic         f_vld, f_zero, c1_vld, s_vld, s_zero, c2_vld, u_vld, u_zero, d_vld;
  ucomp_t [2:0] f_vec, s_vec, u_vec;
  vcomp_t [2:0] c1_vec, c2_vec;
  side_t        f_side, c1_side, s_side, c2_side, u_side;
  side_t        sd1, sd2, sd3;
  word_t  [2:0] fw;
  colset_t      d_cols;

  logic         ob_v_r;
  logic [1:0]   col_r;
  colset_t      ob_r;

  // input register: view direction and item context
  always_comb begin
    view_nxt[0]   = VW'(in_target_x) - VW'(in_eye_x);
    view_nxt[1]   = VW'(in_target_y) - VW'(in_eye_y);
    view_nxt[2]   = VW'(in_target_z) - VW'(in_eye_z);
    sd0_nxt       = '0;
    sd0_nxt.eye   = {in_eye_z, in_eye_y, in_eye_x};
    sd0_nxt.up    = {in_up_z, in_up_y, in_up_x};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      view_r <= view_nxt;
      sd0_r  <= sd0_nxt;
    end
  end

  lav_unit u_unit_f (
    .clk, .rst_n, .en,
    .in_vld(v0_r), .in_vec(view_r), .in_side(sd0_r),
    .out_vld(f_vld), .out_vec(f_vec), .out_zero(f_zero), .out_side(f_side)
  );

  always_comb begin
    sd1       = f_side;
    sd1.f     = f_vec;
    sd1.degen = f_zero;
  end

  lav_cross u_cross_s (
    .clk, .rst_n, .en,
    .in_vld(f_vld), .in_a(f_vec), .in_b(sd1.up), .in_side(sd1),
    .out_vld(c1_vld), .out_vec(c1_vec), .out_side(c1_side)
  );

  lav_unit u_unit_s (
    .clk, .rst_n, .en,
    .in_vld(c1_vld), .in_vec(c1_vec), .in_side(c1_side),
    .out_vld(s_vld), .out_vec(s_vec), .out_zero(s_zero), .out_side(s_side)
  );

  always_comb begin
    sd2       = s_side;
    sd2.s     = s_vec;
    sd2.degen = s_side.degen | s_zero;
    for (int i = 0; i < 3; i++) fw[i] = WW'($signed(s_side.f[i]));
  end

  lav_cross u_cross_u (
    .clk, .rst_n, .en,
    .in_vld(s_vld), .in_a(s_vec), .in_b(fw), .in_side(sd2),
    .out_vld(c2_vld), .out_vec(c2_vec), .out_side(c2_side)
  );

  lav_unit u_unit_u (
    .clk, .rst_n, .en,
    .in_vld(c2_vld), .in_vec(c2_vec), .in_side(c2_side),
    .out_vld(u_vld), .out_vec(u_vec), .out_zero(u_zero), .out_side(u_side)
  );

  always_comb begin
    sd3       = u_side;
    sd3.degen = u_side.degen | u_zero;
  end

  lav_dot u_dot (
    .clk, .rst_n, .en,
    .in_vld(u_vld), .in_s(sd3.s), .in_u(u_vec), .in_f(sd3.f), .in_eye(sd3.eye),
    .in_degen(sd3.degen),
    .out_vld(d_vld), .out_cols(d_cols)
  );

  // output register holds one item and hands out its columns in order
  assign take     = !ob_v_r || (out_ready && col_r == LAST_COL);
  assign en       = !d_vld || take;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_v_r <= 1'b0;
      col_r  <= FIRST_COL;
    end else if (take) begin
      ob_v_r <= d_vld;
      col_r  <= FIRST_COL;
    end else if (out_ready) begin
      col_r  <= col_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) ob_r <= d_cols;
  end

  always_comb begin
    word_t fe;
    fe = '0;
    if (col_r == LAST_COL) begin
      out_row0_value = ob_r.t[0];
      out_row1_value = ob_r.t[1];
      out_row2_value = ob_r.t[2];
      out_row3_value = ONE_Q;
    end else begin
      fe             = WW'($signed(ob_r.f[col_r]));
      out_row0_value = WW'($signed(ob_r.s[col_r]));
      out_row1_value = WW'($signed(ob_r.u[col_r]));
      out_row2_value = -fe;
      out_row3_value = '0;
    end
  end

  assign out_valid        = ob_v_r;
  assign out_column_index = col_r;
  assign out_last_column  = (col_r == LAST_COL);
  assign out_degenerate   = ob_r.degen;

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_column
    |=> out_valid && out_column_index == $past(out_column_index) + 2'd1)
    else $error("column sequence broken");

  a_degen_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_column_index != FIRST_COL |-> out_degenerate == $past(out_degenerate))
    else $error("degenerate flag changed within an item");

  a_load_first: assert property (@(posedge clk) disable iff (!rst_n)
    take && d_vld |=> out_valid && out_column_index == FIRST_COL)
    else $error("new item did not start at column 0");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    d_vld && !take |=> d_vld && $stable(d_cols))
    else $error("finished item lost while output busy");

endmodule

// ----- tb/lav_checker.sv -----
`timescale 1ns / 1ps
// lav_checker: watches both channels of look_at_view_matrix, predicts the four matrix columns
// of every accepted item and compares them with the results. Depends on lav_pkg.
module lav_checker
  import lav_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  word_t      in_eye_x,
  input  word_t      in_eye_y,
  input  word_t      in_eye_z,
  input  word_t      in_target_x,
  input  word_t      in_target_y,
  input  word_t      in_target_z,
  input  word_t      in_up_x,
  input  word_t      in_up_y,
  input  word_t      in_up_z,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_column_index,
  input  word_t      out_row0_value,
  input  word_t      out_row1_value,
  input  word_t      out_row2_value,
  input  word_t      out_row3_value,
  input  logic       out_last_column,
  input  logic       out_degenerate,
  output int         fail_count,
  output int         columns_pending
);

  typedef longint vec3_t [3];

  typedef struct {
    logic [1:0] col;
    word_t      r0, r1, r2, r3;
    logic       last;
    logic       degen;
  } column_t;

  column_t column_q[$];

  assign columns_pending = column_q.size();

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // returns 1 when the vector has zero length
  function automatic bit normalize(input vec3_t v, output vec3_t r);
    longint unsigned a[3];
    longint unsigned m, sq, len, q;
    for (int i = 0; i < 3; i++) a[i] = v[i] < 0 ? -v[i] : v[i];
    m = a[0];
    if (a[1] > m) m = a[1];
    if (a[2] > m) m = a[2];
    if (m == 0) begin
      for (int i = 0; i < 3; i++) r[i] = 0;
      return 1'b1;
    end
    while (m >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
      m = m >> 1;
    end
    while (m < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
      m = m << 1;
    end
    sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    len = floor_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << FRAC_BITS) + (len >> 1)) / len;
      r[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  function automatic vec3_t cross3(input vec3_t a, input vec3_t b);
    vec3_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  // rounded, saturated dot of a unit vector with the eye point
  function automatic word_t eye_dot(input vec3_t a, input vec3_t p, input bit negate);
    longint d;
    longint unsigned m;
    bit neg;
    d = a[0] * p[0] + a[1] * p[1] + a[2] * p[2];
    m = d < 0 ? -d : d;
    neg = (d < 0) != negate;
    m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (neg) return m > 64'h8000_0000 ? word_t'(32'h8000_0000) : word_t'(-longint'(m));
    return m > 64'h7FFF_FFFF ? word_t'(32'h7FFF_FFFF) : word_t'(m);
  endfunction

  task automatic predict_matrix();
    vec3_t eye, view, up, f, s, u, t;
    bit degen;
    column_t c;
    eye[0] = in_eye_x; eye[1] = in_eye_y; eye[2] = in_eye_z;
    view[0] = longint'(in_target_x) - eye[0];
    view[1] = longint'(in_target_y) - eye[1];
    view[2] = longint'(in_target_z) - eye[2];
    up[0] = in_up_x; up[1] = in_up_y; up[2] = in_up_z;
    degen = normalize(view, f);
    t = cross3(f, up);
    degen = normalize(t, s) | degen;
    t = cross3(s, f);
    degen = normalize(t, u) | degen;
    for (int i = 0; i < 3; i++) begin
      c.col = 2'(i);
      c.r0 = word_t'(s[i]);
      c.r1 = word_t'(u[i]);
      c.r2 = word_t'(-f[i]);
      c.r3 = '0;
      c.last = 1'b0;
      c.degen = degen;
      column_q.push_back(c);
    end
    c.col = LAST_COL;
    c.r0 = eye_dot(s, eye, 1'b1);
    c.r1 = eye_dot(u, eye, 1'b1);
    c.r2 = eye_dot(f, eye, 1'b0);
    c.r3 = ONE_Q;
    c.last = 1'b1;
    c.degen = degen;
    column_q.push_back(c);
  endtask

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    column_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (column_q.size() == 0) begin
          $error("column %0d arrived with no item outstanding", out_column_index);
          fail_count++;
        end else begin
          e = column_q.pop_front();
          check_field("column_index", e.col, out_column_index);
          check_field("row0_value", e.r0, out_row0_value);
          check_field("row1_value", e.r1, out_row1_value);
          check_field("row2_value", e.r2, out_row2_value);
          check_field("row3_value", e.r3, out_row3_value);
          check_field("last_column", e.last, out_last_column);
          check_field("degenerate", e.degen, out_degenerate);
        end
      end
      if (in_valid && in_ready) predict_matrix();
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// tb: drives eye/target/up items into look_at_view_matrix with random gaps and stalls,
// and gives the verdict from lav_checker. Depends on lav_pkg, lav_checker and the block.
module tb
  import lav_pkg::*;
();

  localparam int RANDOM_ITEMS = 250;
  localparam int DRAIN_CYCLES = 3 * (FRAC_BITS + 40) + 40;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  word_t      in_eye_x = '0, in_eye_y = '0, in_eye_z = '0;
  word_t      in_target_x = '0, in_target_y = '0, in_target_z = '0;
  word_t      in_up_x = '0, in_up_y = '0, in_up_z = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_column_index;
  word_t      out_row0_value, out_row1_value, out_row2_value, out_row3_value;
  logic       out_last_column, out_degenerate;
  int         fail_count, columns_pending;
  bit         send_calm = 1'b0, recv_calm = 1'b0;

  always #5 clk = ~clk;

  look_at_view_matrix u_top (.*);

  lav_checker u_checker (.*);

  task automatic send_item(input word_t ex, ey, ez, tx, ty, tz, ux, uy, uz);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_eye_x <= ex; in_eye_y <= ey; in_eye_z <= ez;
    in_target_x <= tx; in_target_y <= ty; in_target_z <= tz;
    in_up_x <= ux; in_up_y <= uy; in_up_z <= uz;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic word_t rand_coord();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom);
      1: return word_t'($signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000);
      2: return '0;
      3: return $urandom_range(0, 1) ? word_t'(32'h7FFF_FFFF) : word_t'(32'h8000_0000);
      4: return word_t'(($signed($urandom_range(0, 40)) - 20) <<< FRAC_BITS);
      default: return word_t'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
    endcase
  endfunction

  // result side: random stall before each column, with calm stretches
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = recv_calm ? 0 : $urandom_range(0, 13);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if ($urandom_range(0, 40) == 0) recv_calm = ~recv_calm;
    end
  end

  initial begin
    word_t ex, ey, ez, tx, ty, tz, ux, uy, uz;
    word_t one;
    one = ONE_Q;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero view, textbook camera, zero and parallel up, extremes, saturation
    send_item('0, '0, '0, '0, '0, '0, '0, '0, '0);
    send_item(one, 2 * one, 3 * one, one, 2 * one, 3 * one, '0, one, '0);
    send_item('0, '0, 5 * one, '0, '0, '0, '0, one, '0);
    send_item(one, one, one, -one, 3 * one, -2 * one, '0, '0, '0);
    send_item('0, '0, '0, 4 * one, '0, '0, 7 * one, '0, '0);
    send_item('0, '0, '0, -4 * one, '0, '0, one, '0, '0);
    send_item(32'sh7FFF_FFFF, '0, '0, 32'sh8000_0000, '0, '0, '0, one, '0);
    send_item(32'sh8000_0000, '0, '0, 32'sh7FFF_FFFF, '0, '0, '0, '0, one);
    send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0, '0, '0,
              '0, '0, 32'sh7FFF_FFFF);
    send_item('0, '0, '0, 32'sh0000_0001, '0, '0, '0, 32'sh0000_0001, '0);
    send_item(32'sh0000_8000, -32'sh0000_8000, 32'sh0001_8000, '0, '0, one,
              32'sh0000_0001, 32'sh8000_0000, 32'sh0000_0003);
    send_item('0, '0, '0, one, one, one, one, one, one);
    send_item(-3 * one, '0, '0, 3 * one, '0, '0, 32'sh8000_0000, '0, '0);
    send_item(32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, '0, '0, '0,
              32'shFFFF_FFFF, '0, '0);

    // let the pipe drain completely before random traffic
    @(negedge clk);
    in_valid <= 1'b0;
    wait (columns_pending == 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      ex = rand_coord(); ey = rand_coord(); ez = rand_coord();
      ux = rand_coord(); uy = rand_coord(); uz = rand_coord();
      case ($urandom_range(0, 19))
        0: begin tx = ex; ty = ey; tz = ez; end
        1: begin tx = ex + one; ty = ey; tz = ez; ux = rand_coord(); uy = '0; uz = '0; end
        2: begin
          ux = '0; uy = '0; uz = '0;
          tx = rand_coord(); ty = rand_coord(); tz = rand_coord();
        end
        default: begin tx = rand_coord(); ty = rand_coord(); tz = rand_coord(); end
      endcase
      send_item(ex, ey, ez, tx, ty, tz, ux, uy, uz);
      if ($urandom_range(0, 30) == 0) send_calm = ~send_calm;
      if (n == RANDOM_ITEMS / 2) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait (columns_pending == 0);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    wait (columns_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
